// ----- rtl/core/ohash_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Open-addressed hash table package
// Shared sizes, command and status codes, and the types that carry table
// entries and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package ohash_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;

  localparam int TYPE_W   = 9;
  localparam int HASH_W   = 64;
  localparam int HANDLE_W = 32;
  localparam int SLOT_W   = 8;
  localparam int STAT_W   = 3;
  localparam int CMD_W    = 2;
  localparam int LIMIT_W  = 7;
  localparam int PCT_W    = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd70;
  localparam logic [PCT_W-1:0]   PCT_SCALE   = 7'd100;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [STAT_W-1:0] RES_FOUND   = 3'd0;
  localparam logic [STAT_W-1:0] RES_MISS    = 3'd1;
  localparam logic [STAT_W-1:0] RES_NEW     = 3'd2;
  localparam logic [STAT_W-1:0] RES_UPDATED = 3'd3;
  localparam logic [STAT_W-1:0] RES_REMOVED = 3'd4;
  localparam logic [STAT_W-1:0] RES_FULL    = 3'd5;

  typedef struct packed {
    logic [TYPE_W-1:0]   typ;
    logic [HASH_W-1:0]   hash;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic   tomb;
    entry_t ent;
  } slot_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic compact_start;
    logic sweep;
    logic clear_all;
    logic refill_rd;
    logic probe_start;
    logic probe_eval;
    logic refill_wr;
    logic apply;
    logic refill;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic is_clear;
    logic is_insert;
    logic need_compact;
    logic sweep_done;
    logic refill_more;
    logic probe_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/core/open_addressed_hash_table.sv -----
`timescale 1ns / 1ps
// An insert for which compaction is due first sweeps the live entries into the
// scratch memory and clears the table, then re-probes and rewrites each one
// before its own probe. Commands are taken one at a time, as in_ready is high
// only while idle; a result still waiting holds the final update step until
// it is taken.
// Reset (synchronous, active low): all slots empty, counts zero, limit 70.
// ----------------------------------------------------------------------------
// Open-addressed hash table
// Linear-probing table keyed by type id and key hash, with tombstones,
// in-place compaction before inserts and an APB-style limit register.
// ----------------------------------------------------------------------------
module open_addressed_hash_table
  import ohash_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [TYPE_W-1:0]   in_type_id,
  input  logic [HASH_W-1:0]   in_key_hash,
  input  logic [HANDLE_W-1:0] in_entry_handle,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STAT_W-1:0]   out_status,
  output logic [HANDLE_W-1:0] out_handle_out,
  output logic [SLOT_W-1:0]   out_slot_index,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  ctrl_cmd_t          cmd;
  dp_stat_t           stat;
  logic               cfg_we;
  logic [LIMIT_W-1:0] limit;

  // The single register reads back at address zero, but writes do not decode
  // the address, so every completed write transfer updates it.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr == 2'd0) ? {{(32 - LIMIT_W){1'b0}}, limit} : 32'd0;

  // The controller sequences decode, compaction, probing and the final update.
  ohash_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the table, the counters and the result register, so a
  // finished result waits there while the next transfer is accepted.
  ohash_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_cmd          (in_cmd),
    .in_type_id      (in_type_id),
    .in_key_hash     (in_key_hash),
    .in_entry_handle (in_entry_handle),
    .cfg_we          (cfg_we),
    .cfg_wdata       (pwdata[LIMIT_W-1:0]),
    .limit           (limit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_handle_out  (out_handle_out),
    .out_slot_index  (out_slot_index)
  );

endmodule

// ----- rtl/core/ohash_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table controller
// One-hot sequencer for command decode, compaction sweep and refill, the
// slot probe loop and the final table update.
// ----------------------------------------------------------------------------
module ohash_ctrl
  import ohash_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECIDE = 8'b0000_0010,
    S_SWEEP  = 8'b0000_0100,
    S_REFILL = 8'b0000_1000,
    S_PSTART = 8'b0001_0000,
    S_PRD    = 8'b0010_0000,
    S_PEV    = 8'b0100_0000,
    S_APPLY  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   refill_r, refill_nxt;
  logic   refwr_r, refwr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      refill_r <= 1'b0;
      refwr_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      refill_r <= refill_nxt;
      refwr_r  <= refwr_nxt;
    end
  end

  // The refill write reuses the refill state: refwr_r marks a pending write
  // of the entry just probed.
  always_comb begin
    state_nxt  = state_r;
    refill_nxt = refill_r;
    refwr_nxt  = 1'b0;
    cmd        = '0;
    cmd.refill = refill_r;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_clear) begin
          state_nxt = S_APPLY;
        end else if (stat.is_insert && stat.need_compact) begin
          cmd.compact_start = 1'b1;
          refill_nxt        = 1'b1;
          state_nxt         = S_SWEEP;
        end else begin
          state_nxt = S_PSTART;
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_done) begin
          cmd.clear_all = 1'b1;
          state_nxt     = S_REFILL;
        end
      end
      S_REFILL: begin
        if (refwr_r) begin
          cmd.refill_wr = 1'b1;
        end else if (stat.refill_more) begin
          cmd.refill_rd = 1'b1;
          state_nxt     = S_PSTART;
        end else begin
          refill_nxt = 1'b0;
          state_nxt  = S_PSTART;
        end
      end
      S_PSTART: begin
        cmd.probe_start = 1'b1;
        state_nxt       = S_PRD;
      end
      S_PRD: begin
        state_nxt = S_PEV;
      end
      S_PEV: begin
        cmd.probe_eval = 1'b1;
        if (stat.probe_done) begin
          if (refill_r) begin
            refwr_nxt = 1'b1;
            state_nxt = S_REFILL;
          end else begin
            state_nxt = S_APPLY;
          end
        end else begin
          state_nxt = S_PRD;
        end
      end
      S_APPLY: begin
        if (stat.out_free) begin
          cmd.apply = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/ohash_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table datapath
// Slot and scratch memories, per-slot valid bits, probe registers,
// occupancy counters, the load limit register and the result register.
// ----------------------------------------------------------------------------
module ohash_dp
  import ohash_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_cmd_t           cmd,
  output dp_stat_t            stat,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [TYPE_W-1:0]   in_type_id,
  input  logic [HASH_W-1:0]   in_key_hash,
  input  logic [HANDLE_W-1:0] in_entry_handle,
  input  logic                cfg_we,
  input  logic [LIMIT_W-1:0]  cfg_wdata,
  output logic [LIMIT_W-1:0]  limit,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STAT_W-1:0]   out_status,
  output logic [HANDLE_W-1:0] out_handle_out,
  output logic [SLOT_W-1:0]   out_slot_index
);

  localparam int USED_W = CNT_W + 1;
  localparam int PROD_W = USED_W + PCT_W;

  // Latched command.
  logic [CMD_W-1:0] cmd_r;
  entry_t           in_ent_r;

  // Memories.
  slot_word_t           slot_mem [CAPACITY];
  entry_t               scr_mem  [CAPACITY];
  slot_word_t           rd_q_r;
  entry_t               scr_q_r;
  logic [CAPACITY-1:0]  valid_r;
  logic                 vq_r;

  // Sweep and refill.
  logic [CNT_W-1:0] swp_r;
  logic             cap_pend_r;
  logic [CNT_W-1:0] scr_cnt_r;
  logic [CNT_W-1:0] ref_r;

  // Probe.
  logic [IDX_W-1:0]    pos_r;
  logic [IDX_W-1:0]    steps_r;
  logic                have_tomb_r;
  logic [IDX_W-1:0]    tomb_idx_r;
  logic                hit_r;
  logic                have_r;
  logic [IDX_W-1:0]    idx_r;
  logic                rtomb_r;
  logic [HANDLE_W-1:0] rhandle_r;

  // Counters and configuration.
  logic [CNT_W-1:0]   live_r, live_nxt;
  logic [CNT_W-1:0]   tcnt_r, tcnt_nxt;
  logic [LIMIT_W-1:0] limit_r;

  // Result register.
  logic                out_valid_r;
  logic [STAT_W-1:0]   out_status_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic [SLOT_W-1:0]   out_slot_r;

  entry_t              key;
  logic [IDX_W-1:0]    rd_addr;
  logic                p_empty, p_tomb, p_match, p_last, ht;
  logic [IDX_W-1:0]    ti;
  logic [USED_W-1:0]   used;
  logic [PROD_W-1:0]   prod;
  logic                load_ge;
  logic                out_free;
  logic                mem_we, valid_set, clear_v;
  logic [IDX_W-1:0]    waddr;
  slot_word_t          wdata;
  logic                scr_we;
  logic                out_ld;
  logic [STAT_W-1:0]   res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic [SLOT_W-1:0]   res_slot;

  assign key     = cmd.refill ? scr_q_r : in_ent_r;
  assign rd_addr = cmd.sweep ? swp_r[IDX_W-1:0] : pos_r;

  // Probe step evaluation on the registered slot read.
  assign p_empty = !vq_r;
  assign p_tomb  = vq_r && rd_q_r.tomb;
  assign p_match = vq_r && !rd_q_r.tomb && (rd_q_r.ent.typ == key.typ) &&
                   (rd_q_r.ent.hash == key.hash);
  assign p_last  = (steps_r == IDX_W'(CAPACITY - 1));
  assign ht      = have_tomb_r || p_tomb;
  assign ti      = have_tomb_r ? tomb_idx_r : pos_r;

  // Load percentage floor((live + tomb + 1) * 100 / CAPACITY).
  assign used    = USED_W'(live_r) + USED_W'(tcnt_r) + USED_W'(1);
  assign prod    = PROD_W'(used) * PROD_W'(PCT_SCALE);
  assign load_ge = (prod >> IDX_W) >= PROD_W'(limit_r);

  assign out_free = !out_valid_r || out_ready;
  assign scr_we   = cmd.sweep && cap_pend_r && vq_r && !rd_q_r.tomb;

  assign stat.is_clear     = (cmd_r == CMD_CLEAR);
  assign stat.is_insert    = (cmd_r == CMD_INSERT);
  assign stat.need_compact = (tcnt_r > live_r) || load_ge;
  assign stat.sweep_done   = swp_r[IDX_W] && !cap_pend_r;
  assign stat.refill_more  = (ref_r < scr_cnt_r);
  assign stat.probe_done   = p_empty || p_match || p_last;
  assign stat.out_free     = out_free;

  // Table update, counters and result for the post-sweep clear, the refill write and the apply.
  always_comb begin
    mem_we     = 1'b0;
    valid_set  = 1'b0;
    clear_v    = cmd.clear_all;
    waddr      = idx_r;
    wdata      = {1'b0, key};
    live_nxt   = live_r;
    tcnt_nxt   = tcnt_r;
    out_ld     = 1'b0;
    res_status = RES_MISS;
    res_handle = '0;
    res_slot   = '0;
    if (cmd.clear_all) begin
      live_nxt = '0;
      tcnt_nxt = '0;
    end
    if (cmd.refill_wr && have_r) begin
      mem_we    = 1'b1;
      valid_set = 1'b1;
      if (!hit_r) begin
        live_nxt = live_r + CNT_W'(1);
      end
    end
    if (cmd.apply) begin
      out_ld = 1'b1;
      case (cmd_r)
        CMD_CLEAR: begin
          clear_v    = 1'b1;
          live_nxt   = '0;
          tcnt_nxt   = '0;
          res_status = RES_REMOVED;
        end
        CMD_INSERT: begin
          if (load_ge || !have_r) begin
            res_status = RES_FULL;
          end else begin
            mem_we     = 1'b1;
            valid_set  = 1'b1;
            res_handle = in_ent_r.handle;
            res_slot   = SLOT_W'(idx_r);
            if (hit_r) begin
              res_status = RES_UPDATED;
            end else begin
              res_status = RES_NEW;
              live_nxt   = live_r + CNT_W'(1);
              if (rtomb_r && (tcnt_r != '0)) begin
                tcnt_nxt = tcnt_r - CNT_W'(1);
              end
            end
          end
        end
        CMD_REMOVE: begin
          res_slot = SLOT_W'(idx_r);
          if (hit_r) begin
            mem_we     = 1'b1;
            wdata      = {1'b1, in_ent_r.typ, in_ent_r.hash, rhandle_r};
            res_status = RES_REMOVED;
            res_handle = rhandle_r;
            tcnt_nxt   = tcnt_r + CNT_W'(1);
            if (live_r != '0) begin
              live_nxt = live_r - CNT_W'(1);
            end
          end
        end
        default: begin
          res_slot = SLOT_W'(idx_r);
          if (hit_r) begin
            res_status = RES_FOUND;
            res_handle = rhandle_r;
          end
        end
      endcase
    end
  end

  // Memories: one write and one registered read each.
  always_ff @(posedge clk) begin
    rd_q_r <= slot_mem[rd_addr];
    if (mem_we) begin
      slot_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mem[scr_cnt_r[IDX_W-1:0]] <= rd_q_r.ent;
    end
    if (cmd.refill_rd) begin
      scr_q_r <= scr_mem[ref_r[IDX_W-1:0]];
    end
  end

  // Valid bits: a slot that is not valid reads as empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vq_r    <= 1'b0;
    end else begin
      vq_r <= valid_r[rd_addr];
      if (clear_v) begin
        valid_r <= '0;
      end else if (valid_set) begin
        valid_r[waddr] <= 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r       <= CMD_LOOKUP;
      swp_r       <= '0;
      cap_pend_r  <= 1'b0;
      scr_cnt_r   <= '0;
      ref_r       <= '0;
      live_r      <= '0;
      tcnt_r      <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      live_r <= live_nxt;
      tcnt_r <= tcnt_nxt;
      if (cmd.load) begin
        cmd_r <= in_cmd;
      end
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (cmd.compact_start) begin
        swp_r      <= '0;
        cap_pend_r <= 1'b0;
        scr_cnt_r  <= '0;
        ref_r      <= '0;
      end else if (cmd.sweep) begin
        if (!swp_r[IDX_W]) begin
          swp_r      <= swp_r + CNT_W'(1);
          cap_pend_r <= 1'b1;
        end else begin
          cap_pend_r <= 1'b0;
        end
        if (scr_we) begin
          scr_cnt_r <= scr_cnt_r + CNT_W'(1);
        end
      end
      if (cmd.refill_rd) begin
        ref_r <= ref_r + CNT_W'(1);
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_ent_r <= {in_type_id, in_key_hash, in_entry_handle};
    end
    if (cmd.probe_start) begin
      pos_r       <= key.hash[IDX_W-1:0];
      steps_r     <= '0;
      have_tomb_r <= 1'b0;
      tomb_idx_r  <= '0;
    end else if (cmd.probe_eval) begin
      pos_r       <= pos_r + IDX_W'(1);
      steps_r     <= steps_r + IDX_W'(1);
      have_tomb_r <= ht;
      tomb_idx_r  <= ti;
      rhandle_r   <= rd_q_r.ent.handle;
      if (p_match) begin
        hit_r   <= 1'b1;
        have_r  <= 1'b1;
        idx_r   <= pos_r;
        rtomb_r <= 1'b0;
      end else if (p_empty) begin
        hit_r   <= 1'b0;
        have_r  <= 1'b1;
        idx_r   <= have_tomb_r ? tomb_idx_r : pos_r;
        rtomb_r <= have_tomb_r;
      end else begin
        hit_r   <= 1'b0;
        have_r  <= ht;
        idx_r   <= ht ? ti : '0;
        rtomb_r <= ht;
      end
    end
    if (out_ld) begin
      out_status_r <= res_status;
      out_handle_r <= res_handle;
      out_slot_r   <= res_slot;
    end
  end

  assign limit          = limit_r;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_handle_out = out_handle_r;
  assign out_slot_index = out_slot_r;

endmodule

// ----- rtl/core/ohash_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table port checker
// Port-level checks on the result channel, attached to the top level.
// ----------------------------------------------------------------------------
module ohash_checker
  import ohash_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STAT_W-1:0]   out_status,
  input logic [HANDLE_W-1:0] out_handle_out,
  input logic [SLOT_W-1:0]   out_slot_index
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_handle_out))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= RES_FULL)
    else $error("status code out of range");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == RES_FULL |-> out_handle_out == '0 && out_slot_index == '0)
    else $error("refused insert carries a handle or slot");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == RES_MISS |-> out_handle_out == '0)
    else $error("miss carries a handle");

endmodule

bind open_addressed_hash_table ohash_checker u_ohash_checker (.*);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Open-addressed hash table testbench
// Drives lookup, insert, remove and clear commands through the valid/ready
// input channel and checks every result against a behavioural model of the
// probing table held in the bench. A short table of directed commands is
// followed by random phases at several load limits, written over the
// configuration port while the table is idle.
// ----------------------------------------------------------------------------
module tb
  import ohash_pkg::*;
();

  // Slot states of the bench's own copy of the table.
  typedef enum logic [1:0] {SLOT_EMPTY, SLOT_LIVE, SLOT_TOMB} slot_st_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [HANDLE_W-1:0] handle;
    logic [SLOT_W-1:0]   slot;
  } outcome_t;

  typedef struct packed {
    logic          hit;
    logic          have_slot;
    logic [7:0]    index;
  } probe_t;

  typedef struct packed {
    logic [TYPE_W-1:0] typ;
    logic [HASH_W-1:0] hash;
  } key_t;

  // One row of the directed table; typed rows carry their expected result.
  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [TYPE_W-1:0]   typ;
    logic [HASH_W-1:0]   hash;
    logic [HANDLE_W-1:0] handle;
    bit                  typed;
    outcome_t            want;
  } row_t;

  localparam int SLOTS = CAPACITY;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [CMD_W-1:0]    in_cmd;
  logic [TYPE_W-1:0]   in_type_id;
  logic [HASH_W-1:0]   in_key_hash;
  logic [HANDLE_W-1:0] in_entry_handle;
  logic                out_valid;
  logic                out_ready;
  logic [STAT_W-1:0]   out_status;
  logic [HANDLE_W-1:0] out_handle_out;
  logic [SLOT_W-1:0]   out_slot_index;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [1:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  open_addressed_hash_table i_dut (.*);

  // Bench copy of the table contents, counters and load limit.
  slot_st_t            tbl_state [SLOTS];
  logic [TYPE_W-1:0]   tbl_type  [SLOTS];
  logic [HASH_W-1:0]   tbl_hash  [SLOTS];
  logic [HANDLE_W-1:0] tbl_handle[SLOTS];
  int                  n_live;
  int                  n_tomb;
  int                  load_limit;

  outcome_t            pending_results[$];
  key_t                key_pool[$];
  int                  fails;
  bit                  sender_calm;
  bit                  receiver_calm;

  // 4 ns clock.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Walks the probe sequence from hash AND mask, remembering the first
  // tombstone and stopping at the first empty slot or at a matching key.
  function automatic probe_t probe_key(logic [TYPE_W-1:0] t, logic [HASH_W-1:0] h);
    probe_t r;
    bit     have_tomb;
    int     tomb_at;
    int     i;
    r         = '0;
    have_tomb = 0;
    tomb_at   = 0;
    for (int n = 0; n < SLOTS; n++) begin
      i = (int'(h[7:0]) + n) % SLOTS;
      if (tbl_state[i] == SLOT_EMPTY) begin
        r.have_slot = 1'b1;
        r.index     = have_tomb ? tomb_at[7:0] : i[7:0];
        return r;
      end
      if (tbl_state[i] == SLOT_TOMB) begin
        if (!have_tomb) begin
          have_tomb = 1;
          tomb_at   = i;
        end
        continue;
      end
      if (tbl_type[i] == t && tbl_hash[i] == h) begin
        r.hit       = 1'b1;
        r.have_slot = 1'b1;
        r.index     = i[7:0];
        return r;
      end
    end
    if (have_tomb) begin
      r.have_slot = 1'b1;
      r.index     = tomb_at[7:0];
    end
    return r;
  endfunction

  function automatic int load_now();
    return ((n_live + n_tomb + 1) * 100) / SLOTS;
  endfunction

  function automatic void empty_table();
    foreach (tbl_state[i]) tbl_state[i] = SLOT_EMPTY;
    n_live = 0;
    n_tomb = 0;
  endfunction

  // Rehashes the live entries in slot order into an emptied table.
  function automatic void compact_table();
    key_t                keys[$];
    logic [HANDLE_W-1:0] vals[$];
    probe_t              r;
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_state[i] == SLOT_LIVE) begin
        keys.push_back({tbl_type[i], tbl_hash[i]});
        vals.push_back(tbl_handle[i]);
      end
    end
    empty_table();
    foreach (keys[k]) begin
      r = probe_key(keys[k].typ, keys[k].hash);
      if (!r.have_slot) continue;
      if (!r.hit) begin
        tbl_state[r.index] = SLOT_LIVE;
        n_live++;
      end
      tbl_type[r.index]   = keys[k].typ;
      tbl_hash[r.index]   = keys[k].hash;
      tbl_handle[r.index] = vals[k];
    end
  endfunction

  function automatic outcome_t apply_command(logic [CMD_W-1:0] cmd, logic [TYPE_W-1:0] t,
                                             logic [HASH_W-1:0] h, logic [HANDLE_W-1:0] v);
    outcome_t o;
    probe_t   r;
    o = '{status: RES_MISS, handle: '0, slot: '0};
    case (cmd)
      CMD_CLEAR: begin
        empty_table();
        o.status = RES_REMOVED;
      end
      CMD_INSERT: begin
        if (n_tomb > n_live || load_now() >= load_limit) compact_table();
        r = probe_key(t, h);
        if (load_now() >= load_limit || !r.have_slot) begin
          o.status = RES_FULL;
        end else begin
          if (r.hit) begin
            o.status = RES_UPDATED;
          end else begin
            if (tbl_state[r.index] == SLOT_TOMB && n_tomb > 0) n_tomb--;
            tbl_state[r.index] = SLOT_LIVE;
            n_live++;
            o.status = RES_NEW;
          end
          tbl_type[r.index]   = t;
          tbl_hash[r.index]   = h;
          tbl_handle[r.index] = v;
          o.handle = v;
          o.slot   = r.index;
        end
      end
      default: begin
        r      = probe_key(t, h);
        o.slot = r.index;
        if (r.hit) begin
          o.handle = tbl_handle[r.index];
          if (cmd == CMD_REMOVE) begin
            tbl_state[r.index] = SLOT_TOMB;
            if (n_live > 0) n_live--;
            n_tomb++;
            o.status = RES_REMOVED;
          end else begin
            o.status = RES_FOUND;
          end
        end
      end
    endcase
    return o;
  endfunction

  // Sends one command. The gap before valid rises is drawn afresh for each
  // transfer; valid is only lowered when a gap actually follows, so a
  // back-to-back command never sees valid fall and rise within one step.
  // The expectation is recorded at the edge that completes the transfer.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [TYPE_W-1:0] t,
                              logic [HASH_W-1:0] h, logic [HANDLE_W-1:0] v,
                              bit typed = 0, outcome_t want = '0);
    int       gap;
    outcome_t o;
    if ($urandom_range(0, 19) == 0) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_type_id      <= t;
    in_key_hash     <= h;
    in_entry_handle <= v;
    do @(posedge clk); while (!in_ready);
    o = apply_command(cmd, t, h, v);
    pending_results.push_back(typed ? want : o);
  endtask

  // Holds the sender back until every outstanding result has been returned.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Writes the load limit over the configuration port and reads it back.
  task automatic write_load_limit(int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 2'd0;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    load_limit = value & 8'h7f;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[LIMIT_W-1:0] !== load_limit[LIMIT_W-1:0]) begin
      $error("load_limit_percent: expected %0d, got %0d", load_limit, prdata);
      fails++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Fresh key set. Clustered pools pile their hashes onto a few home slots
  // so that probes run long and wrap past tombstones.
  task automatic build_pool(int count, bit clustered);
    key_t k;
    key_pool.delete();
    repeat (count) begin
      k.typ  = TYPE_W'($urandom_range(0, 511));
      k.hash = {$urandom(), $urandom()};
      if (clustered) k.hash[7:0] = 8'($urandom_range(0, 15));
      key_pool.push_back(k);
    end
  endtask

  // Random traffic over the current pool. Weights are percentages of lookup,
  // insert and remove; the rest are clears. Lookups and removes sometimes
  // use a stray key, often one that differs from a pooled key in type only.
  task automatic random_phase(int count, int w_look, int w_ins, int w_rem);
    int                 r;
    key_t               k;
    logic [CMD_W-1:0]   cmd;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < w_look)                    cmd = CMD_LOOKUP;
      else if (r < w_look + w_ins)       cmd = CMD_INSERT;
      else if (r < w_look + w_ins + w_rem) cmd = CMD_REMOVE;
      else                               cmd = CMD_CLEAR;
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (cmd != CMD_INSERT && $urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) k.typ = k.typ ^ 9'($urandom_range(1, 511));
        else k.hash = {$urandom(), $urandom()};
      end
      send_command(cmd, k.typ, k.hash, $urandom());
    end
  endtask

  // Receiver: a fresh stall is drawn for every result, with calm stretches.
  initial begin
    int stall;
    out_ready     = 1'b0;
    receiver_calm = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if ($urandom_range(0, 19) == 0) receiver_calm = !receiver_calm;
      stall = receiver_calm ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Result checker: every transfer on the result channel is compared with
  // the oldest outstanding expectation.
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d handle %0h slot %0d",
               out_status, out_handle_out, out_slot_index);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fails++;
        end
        if (out_handle_out !== want.handle) begin
          $error("handle_out: expected %0h, got %0h", want.handle, out_handle_out);
          fails++;
        end
        if (out_slot_index !== want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, out_slot_index);
          fails++;
        end
      end
    end
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #200_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    row_t rows[$];
    key_t k;
    fails           = 0;
    sender_calm     = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_cmd          = CMD_LOOKUP;
    in_type_id      = '0;
    in_key_hash     = '0;
    in_entry_handle = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    load_limit      = LIMIT_RESET;
    empty_table();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed commands from reset. Rows with a typed result are those that
    // follow directly from an empty table, an extreme key or a clear.
    rows = '{
      '{CMD_LOOKUP, 9'd0,   64'd0, 32'd0, 1, '{RES_MISS, 32'd0, 8'd0}},
      '{CMD_REMOVE, 9'd511, '1,    32'd0, 1, '{RES_MISS, 32'd0, 8'd255}},
      '{CMD_INSERT, 9'd0,   64'd0, '1,    1, '{RES_NEW, 32'hffff_ffff, 8'd0}},
      '{CMD_LOOKUP, 9'd0,   64'd0, 32'd0, 1, '{RES_FOUND, 32'hffff_ffff, 8'd0}},
      '{CMD_INSERT, 9'd511, 64'd0, 32'd0, 0, '0},
      '{CMD_INSERT, 9'd256, 64'd0, 32'h8000_0001, 0, '0},
      '{CMD_INSERT, 9'd0,   64'd0, 32'h1234_5678, 0, '0},
      '{CMD_REMOVE, 9'd0,   64'd0, 32'd0, 0, '0},
      '{CMD_LOOKUP, 9'd0,   64'd0, 32'd0, 0, '0},
      '{CMD_LOOKUP, 9'd511, 64'd0, 32'd0, 0, '0},
      '{CMD_REMOVE, 9'd1,   64'd0, 32'd0, 0, '0},
      '{CMD_INSERT, 9'd5,   64'h100, 32'h5555_aaaa, 0, '0},
      '{CMD_INSERT, 9'd511, '1,    32'h0f0f_0f0f, 0, '0},
      '{CMD_INSERT, 9'd1,   64'h8000_0000_0000_00ff, 32'haaaa_5555, 0, '0},
      '{CMD_LOOKUP, 9'd1,   64'h8000_0000_0000_00ff, 32'd0, 0, '0},
      '{CMD_REMOVE, 9'd511, '1,    32'd0, 0, '0},
      '{CMD_REMOVE, 9'd256, 64'd0, 32'd0, 0, '0},
      '{CMD_INSERT, 9'd7,   64'h7fff_ffff_ffff_ff00, 32'h0000_0001, 0, '0},
      '{CMD_CLEAR,  9'd0,   64'd0, 32'd0, 1, '{RES_REMOVED, 32'd0, 8'd0}},
      '{CMD_LOOKUP, 9'd1,   64'h8000_0000_0000_00ff, 32'd0, 1, '{RES_MISS, 32'd0, 8'd255}}
    };
    foreach (rows[i])
      send_command(rows[i].cmd, rows[i].typ, rows[i].hash, rows[i].handle,
                   rows[i].typed, rows[i].want);

    // Every pause below waits for the table to go quiet before the limit
    // register is touched, which also gives the sender its full hold-off.
    drain_results();
    write_load_limit(70);
    build_pool(48, 0);
    random_phase(480, 35, 35, 27);

    // Limits above 100 are never reached by the load, so the table fills to
    // the last slot and only an exhausted probe is refused.
    drain_results();
    write_load_limit(127);
    send_command(CMD_CLEAR, '0, '0, '0);
    key_pool.delete();
    for (int i = 0; i < SLOTS + 6; i++) begin
      k.typ  = TYPE_W'($urandom_range(0, 511));
      k.hash = {$urandom(), $urandom()};
      k.hash[7:0] = i[7:0];
      key_pool.push_back(k);
      send_command(CMD_INSERT, k.typ, k.hash, $urandom());
    end
    random_phase(30, 50, 40, 10);

    // A limit of one: a full table is compacted and the insert refused.
    drain_results();
    write_load_limit(1);
    random_phase(60, 40, 40, 20);
    send_command(CMD_CLEAR, '0, '0, '0);
    build_pool(16, 1);
    random_phase(60, 40, 40, 18);

    // A limit of zero refuses every insert after compacting.
    drain_results();
    write_load_limit(0);
    random_phase(50, 30, 50, 20);

    // A limit of 100: a dense table with long probes, no removals.
    drain_results();
    write_load_limit(100);
    send_command(CMD_CLEAR, '0, '0, '0);
    build_pool(240, 0);
    random_phase(300, 40, 60, 0);

    // Clustered keys with heavy removal, so tombstones drive compaction.
    drain_results();
    write_load_limit(70);
    send_command(CMD_CLEAR, '0, '0, '0);
    build_pool(100, 1);
    random_phase(350, 30, 38, 30);

    // Mid limit where load rather than tombstones triggers compaction.
    drain_results();
    write_load_limit(50);
    send_command(CMD_CLEAR, '0, '0, '0);
    build_pool(200, 0);
    random_phase(300, 30, 50, 19);

    drain_results();
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
